FILE: hdl/mwfvh_pkg.sv
`timescale 1ns / 1ps

package mwfvh_pkg;

  // Maze geometry
  localparam int MAX_DIM  = 128;
  localparam int DIM_W    = $clog2(MAX_DIM);
  localparam int CELL_W   = 2 * DIM_W;
  localparam int CELLS    = MAX_DIM * MAX_DIM;
  localparam int WALK_CAP = 4 * CELLS + 4;
  localparam int STEP_W   = $clog2(WALK_CAP + 1);
  localparam int DIVC_W   = $clog2(CELL_W);

  // Fixed field widths
  localparam int CFG_W   = 8;
  localparam int CIDX_W  = 1;
  localparam int BIN_W   = 3;
  localparam int TALLY_W = 15;
  localparam int CNT_W   = 3;
  localparam int NBINS   = 5;

  localparam logic [CNT_W-1:0] SAT_COUNT = 3'd7;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_ROWS = 1'b0;
  localparam logic [CIDX_W-1:0] CFG_COLS = 1'b1;

  typedef enum logic [1:0] {
    HEAD_E = 2'd0,
    HEAD_S = 2'd1,
    HEAD_W = 2'd2,
    HEAD_N = 2'd3
  } heading_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic walk_rd;
    logic walk_dec;
    logic walk_inc;
    logic clear;
    logic sweep;
    logic emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic load_last;
    logic div_done;
    logic moved;
    logic dec_end;
    logic inc_end;
    logic clear_last;
    logic sweep_last;
    logic emit_last;
  } status_t;

  typedef struct packed {
    logic             ok;
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] col;
  } nb_t;

  // Register value to effective dimension: 0 acts as 1, above MAX_DIM clamps
  function automatic logic [DIM_W:0] eff_dim(logic [CFG_W-1:0] v);
    logic [DIM_W:0] d;
    if (v == '0) d = (DIM_W+1)'(1);
    else if (int'(v) > MAX_DIM) d = (DIM_W+1)'(MAX_DIM);
    else d = (DIM_W+1)'(v);
    return d;
  endfunction

  // Neighbor cell one step in a direction, with range check
  function automatic nb_t nb_step(logic [DIM_W-1:0] row, logic [DIM_W-1:0] col,
                                  heading_t dir, logic [DIM_W:0] nr, logic [DIM_W:0] nc);
    nb_t n;
    n.row = row;
    n.col = col;
    n.ok  = 1'b0;
    unique case (dir)
      HEAD_E: begin
        n.col = col + DIM_W'(1);
        n.ok  = (({1'b0, col} + (DIM_W+1)'(1)) < nc);
      end
      HEAD_S: begin
        n.row = row + DIM_W'(1);
        n.ok  = (({1'b0, row} + (DIM_W+1)'(1)) < nr);
      end
      HEAD_W: begin
        n.col = col - DIM_W'(1);
        n.ok  = (col != '0);
      end
      HEAD_N: begin
        n.row = row - DIM_W'(1);
        n.ok  = (row != '0);
      end
      default: n.ok = 1'b0;
    endcase
    return n;
  endfunction

endpackage

FILE: hdl/mwfvh_ctrl.sv
`timescale 1ns / 1ps

module mwfvh_ctrl
  import mwfvh_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    cfg_write,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV_INIT,
    ST_DIV,
    ST_WALK_RD,
    ST_WALK_DEC,
    ST_WALK_INC,
    ST_HIST,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  state_t state, state_next;

  // Command decode and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        cmd.load = start;
        if (start && status.load_last) state_next = ST_WALK_RD;
        else if (cfg_write) state_next = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        if (!cfg_write) state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cfg_write) state_next = ST_DIV_INIT;
        else if (status.div_done) state_next = ST_IDLE;
      end
      ST_WALK_RD: begin
        cmd.walk_rd = 1'b1;
        state_next  = ST_WALK_DEC;
      end
      ST_WALK_DEC: begin
        cmd.walk_dec = 1'b1;
        priority if (status.moved) state_next = ST_WALK_INC;
        else if (status.dec_end) state_next = ST_HIST;
        else state_next = ST_WALK_RD;
      end
      ST_WALK_INC: begin
        cmd.walk_inc = 1'b1;
        state_next   = status.inc_end ? ST_HIST : ST_WALK_RD;
      end
      ST_HIST: begin
        cmd.sweep = 1'b1;
        if (status.sweep_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_EMIT;
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (status.emit_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      busy  <= 1'b1;
    end else begin
      state <= state_next;
      busy  <= (state_next != ST_IDLE);
    end
  end

  // Busy tracks the state exactly
  a_busy_idle: assert property (@(posedge clk) disable iff (rst)
    busy == (state != ST_IDLE)) else $error("busy out of step with state");

  // A move always gets its counter update next
  a_move_inc: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK_DEC && status.moved) |=> (state == ST_WALK_INC))
    else $error("move without counter update");

  // Histogram drain leads straight to emitting
  a_drain_emit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |=> (state == ST_EMIT)) else $error("drain not followed by emit");

endmodule

FILE: hdl/mwfvh_datapath.sv
`timescale 1ns / 1ps

module mwfvh_datapath
  import mwfvh_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output status_t             status,
  input  logic                cell_is_wall,
  input  logic                cfg_write,
  input  logic [CIDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  output logic                result_strobe,
  output logic [BIN_W-1:0]    visit_bin,
  output logic [TALLY_W-1:0]  cell_tally,
  output logic                final_bin
);

  // Configuration
  logic [CFG_W-1:0] maze_rows, maze_cols;
  logic [DIM_W:0]   nr, nc;
  logic [2*DIM_W+1:0] total;

  always_ff @(posedge clk) begin
    if (rst) begin
      maze_rows <= CFG_W'(1);
      maze_cols <= CFG_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ROWS: maze_rows <= cfg_data;
        CFG_COLS: maze_cols <= cfg_data;
        default:  ;
      endcase
    end
  end

  assign nr    = eff_dim(maze_rows);
  assign nc    = eff_dim(maze_cols);
  assign total = (2*DIM_W+2)'(nr) * (2*DIM_W+2)'(nc);

  logic [DIM_W-1:0] start_row;
  assign start_row = DIM_W'(nr - (DIM_W+1)'(1));

  // Load position and its row/column split
  logic [CELL_W-1:0] lp;
  logic [CELL_W-1:0] lrow;
  logic [DIM_W-1:0]  lcol;
  logic              lp_in;
  logic [CELL_W:0]   lp_inc;

  assign lp_in            = ({2'b0, lp} < total);
  assign lp_inc           = {1'b0, lp} + (CELL_W+1)'(1);
  assign status.load_last = ({1'b0, lp_inc} >= total);

  // Restoring divider: lp / nc, one quotient bit per cycle
  logic [CELL_W-1:0] div_q, div_q_next;
  logic [DIM_W+1:0]  div_rem, div_rem_next, rem_sh;
  logic [DIVC_W-1:0] div_cnt;

  assign rem_sh = {div_rem[DIM_W:0], div_q[CELL_W-1]};
  always_comb begin
    if (rem_sh >= {1'b0, nc}) begin
      div_rem_next = rem_sh - {1'b0, nc};
      div_q_next   = {div_q[CELL_W-2:0], 1'b1};
    end else begin
      div_rem_next = rem_sh;
      div_q_next   = {div_q[CELL_W-2:0], 1'b0};
    end
  end
  assign status.div_done = (div_cnt == DIVC_W'(CELL_W - 1));

  // Robot
  logic [DIM_W-1:0]  rob_row, rob_col;
  heading_t          heading, hd_right, hd_left;
  logic [STEP_W-1:0] steps, steps_next;
  nb_t               nb_r, nb_f;
  logic              rok_q, fok_q;
  logic              wall_qa, wall_qb;
  logic              right_open, front_open;
  logic [DIM_W-1:0]  row_next, col_next;

  assign hd_right   = heading_t'(heading + 2'd1);
  assign hd_left    = heading_t'(heading + 2'd3);
  assign nb_r       = nb_step(rob_row, rob_col, hd_right, nr, nc);
  assign nb_f       = nb_step(rob_row, rob_col, heading, nr, nc);
  assign right_open = rok_q & ~wall_qa;
  assign front_open = fok_q & ~wall_qb;
  assign steps_next = steps + STEP_W'(1);

  always_comb begin
    row_next = rob_row;
    col_next = rob_col;
    priority if (right_open) begin
      row_next = nb_r.row;
      col_next = nb_r.col;
    end else if (front_open) begin
      row_next = nb_f.row;
      col_next = nb_f.col;
    end
  end

  assign status.moved   = right_open | front_open;
  assign status.dec_end = ((row_next == start_row) && (col_next == '0)) ||
                          (steps_next == STEP_W'(WALK_CAP));
  assign status.inc_end = ((rob_row == start_row) && (rob_col == '0)) ||
                          (steps == STEP_W'(WALK_CAP));

  // Sweep address for reset clearing and the histogram pass
  logic [CELL_W-1:0] sweep_pos;
  logic [DIM_W-1:0]  sw_row, sw_col;
  assign sw_row            = sweep_pos[CELL_W-1:DIM_W];
  assign sw_col            = sweep_pos[DIM_W-1:0];
  assign status.clear_last = &sweep_pos;
  assign status.sweep_last = (sw_row == start_row) &&
                             (sw_col == DIM_W'(nc - (DIM_W+1)'(1)));

  // Histogram and emit
  logic [TALLY_W-1:0] tally [NBINS];
  logic [BIN_W-1:0]   emit_idx;
  logic               hist_vld;
  logic [CNT_W-1:0]   cnt_q;
  assign status.emit_last = (emit_idx == BIN_W'(NBINS - 1));

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lp        <= '0;
      lrow      <= '0;
      lcol      <= '0;
      div_q     <= '0;
      div_rem   <= '0;
      div_cnt   <= '0;
      rob_row   <= '0;
      rob_col   <= '0;
      heading   <= HEAD_E;
      steps     <= '0;
      sweep_pos <= '0;
      emit_idx  <= '0;
      hist_vld  <= 1'b0;
      for (int i = 0; i < NBINS; i++) tally[i] <= '0;
    end else begin
      hist_vld <= cmd.sweep;

      // Cell load
      if (cmd.load) begin
        if (status.load_last) begin
          lp        <= '0;
          lrow      <= '0;
          lcol      <= '0;
          rob_row   <= start_row;
          rob_col   <= '0;
          heading   <= HEAD_E;
          steps     <= '0;
          sweep_pos <= '0;
          emit_idx  <= '0;
          for (int i = 0; i < NBINS; i++) tally[i] <= '0;
        end else begin
          lp <= lp_inc[CELL_W-1:0];
          if (({1'b0, lcol} + (DIM_W+1)'(1)) == nc) begin
            lcol <= '0;
            lrow <= lrow + CELL_W'(1);
          end else begin
            lcol <= lcol + DIM_W'(1);
          end
        end
      end

      // Reposition after a configuration write
      if (cmd.div_init) begin
        div_q   <= lp;
        div_rem <= '0;
        div_cnt <= '0;
      end
      if (cmd.div_step) begin
        div_q   <= div_q_next;
        div_rem <= div_rem_next;
        div_cnt <= div_cnt + DIVC_W'(1);
        if (status.div_done) begin
          lrow <= div_q_next;
          lcol <= div_rem_next[DIM_W-1:0];
        end
      end

      // Walk step
      if (cmd.walk_rd) begin
        rok_q <= nb_r.ok;
        fok_q <= nb_f.ok;
      end
      if (cmd.walk_dec) begin
        rob_row <= row_next;
        rob_col <= col_next;
        steps   <= steps_next;
        priority if (right_open) heading <= hd_right;
        else if (!front_open) heading <= hd_left;
      end

      // Sweeps
      if (cmd.clear) sweep_pos <= sweep_pos + CELL_W'(1);
      if (cmd.sweep) begin
        priority if (status.sweep_last) sweep_pos <= '0;
        else if (({1'b0, sw_col} + (DIM_W+1)'(1)) == nc) sweep_pos <= {sw_row + DIM_W'(1), DIM_W'(0)};
        else sweep_pos <= sweep_pos + CELL_W'(1);
      end

      // Tally update in the cycle after the sweep read
      if (hist_vld && !wall_qa && (cnt_q < CNT_W'(NBINS)))
        tally[cnt_q] <= tally[cnt_q] + TALLY_W'(1);

      if (cmd.emit) emit_idx <= emit_idx + BIN_W'(1);
    end
  end

  // Wall map: one write port, two registered read ports
  logic                wall_mem [CELLS];
  logic [CELL_W-1:0]   wall_wa, wall_ra, wall_rb;
  logic                wall_we;

  assign wall_we = cmd.load & lp_in;
  assign wall_wa = {lrow[DIM_W-1:0], lcol};
  assign wall_ra = cmd.walk_rd ? {nb_r.row, nb_r.col} : sweep_pos;
  assign wall_rb = {nb_f.row, nb_f.col};

  always_ff @(posedge clk) begin
    if (wall_we) wall_mem[wall_wa] <= cell_is_wall;
    wall_qa <= wall_mem[wall_ra];
    wall_qb <= wall_mem[wall_rb];
  end

  // Visit counters: cleared by the pass after reset, incremented on a move, zeroed as the
  // histogram reads them so they are clear for the next walk
  logic [CNT_W-1:0]  cnt_mem [CELLS];
  logic [CELL_W-1:0] cnt_wa, cnt_ra;
  logic [CNT_W-1:0]  cnt_wd;
  logic              cnt_we;

  assign cnt_we = cmd.clear | cmd.sweep | cmd.walk_inc;
  assign cnt_wa = cmd.walk_inc ? {rob_row, rob_col} : sweep_pos;
  assign cnt_wd = !cmd.walk_inc ? '0 :
                  (cnt_q == SAT_COUNT) ? SAT_COUNT : cnt_q + CNT_W'(1);
  assign cnt_ra = cmd.walk_dec ? {row_next, col_next} : sweep_pos;

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    cnt_q <= cnt_mem[cnt_ra];
  end

  // Result beats
  always_ff @(posedge clk) begin
    if (rst) result_strobe <= 1'b0;
    else result_strobe <= cmd.emit;
    visit_bin  <= emit_idx;
    cell_tally <= tally[emit_idx];
    final_bin  <= status.emit_last;
  end

  // Load split stays consistent with the column count
  a_lcol_range: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> ({1'b0, lcol} < nc)) else $error("load column out of range");

  // Walk position always inside the maze
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    cmd.walk_rd |-> (({1'b0, rob_row} < nr) && ({1'b0, rob_col} < nc)))
    else $error("robot outside maze");

  // Sweep covers only cells in range
  a_sweep_range: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep |-> (({1'b0, sw_row} < nr) && ({1'b0, sw_col} < nc)))
    else $error("histogram sweep outside maze");

endmodule

FILE: hdl/maze_wall_follow_visit_histogram.sv
`timescale 1ns / 1ps

// Right-hand wall follower with visit histogram. Maze cells load one per cycle
// (start with busy low) in row-major order. The last cell starts the walk from
// the bottom-left cell facing east; busy stays high through the walk, the
// histogram pass and the first four result beats, and drops in the cycle of the
// fifth beat, so the next cell can be taken there. A walk step reads the wall
// map and decides; a move then updates the visit counter, while a turn in place
// goes straight to the next read. The histogram pass sweeps the counter memory,
// then results for bins 0..4 come out as an unbroken run, final_bin marking
// bin 4. The result beats cannot be held off. After reset a clearing pass over
// the whole counter memory zeroes the visit counters with busy high. Each
// configuration write made with busy low holds busy high while the load
// position is re-split into row and column by a bit-serial divider.
module maze_wall_follow_visit_histogram
  import mwfvh_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cell_is_wall,
  input  logic               cfg_write,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  output logic               result_strobe,
  output logic [BIN_W-1:0]   visit_bin,
  output logic [TALLY_W-1:0] cell_tally,
  output logic               final_bin
);

  cmd_t    cmd;
  status_t status;

  mwfvh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cfg_write (cfg_write),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy)
  );

  mwfvh_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cell_is_wall  (cell_is_wall),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .result_strobe (result_strobe),
    .visit_bin     (visit_bin),
    .cell_tally    (cell_tally),
    .final_bin     (final_bin)
  );

  // Bins come out as an unbroken run ending in the final bin
  a_run: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !final_bin) |=> result_strobe) else $error("result run broken");

  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && final_bin) |=> !result_strobe) else $error("result run too long");

  a_final_bin: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> (final_bin == (visit_bin == BIN_W'(NBINS - 1))))
    else $error("final flag on wrong bin");

  a_accept_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !result_strobe) else $error("result beat right after a load");

endmodule
